>>> rtl/color_sort_qualifier_core_assert.svh
// Assertion macros used by the checker file of the color sort qualifier.
`ifndef COLOR_SORT_QUALIFIER_CORE_ASSERT_SVH
`define COLOR_SORT_QUALIFIER_CORE_ASSERT_SVH

// Concurrent assertion on clk, held off while rst_n is low.
`define CSQ_ASSERT(label, prop, msg) \
  label: assert property (@(posedge clk) disable iff (!rst_n) (prop)) else $error(msg);

// Concurrent assertion on clk that is also checked during reset.
`define CSQ_ASSERT_ALWAYS(label, prop, msg) \
  label: assert property (@(posedge clk) (prop)) else $error(msg);

`endif

>>> rtl/csq_pkg.sv
// Shared types, codes and constants of the color sort qualifier.
package csq_pkg;

  localparam int HUE_W      = 9;
  localparam int HUE_WINDOW = 5;
  localparam int POS_W      = (HUE_WINDOW > 1) ? $clog2(HUE_WINDOW) : 1;
  localparam int FILL_W     = $clog2(HUE_WINDOW + 1);
  localparam int RUN_W      = 4;
  localparam int COOL_W     = 8;
  localparam int TGT_W      = 2;
  localparam int CFG_IDX_W  = 3;
  localparam int CFG_DATA_W = 9;

  typedef logic [HUE_WINDOW-1:0][HUE_W-1:0] hue_win_t;

  typedef enum logic [2:0] {
    PH_DISABLED = 3'd0,
    PH_WAIT_CLR = 3'd1,
    PH_COOLDOWN = 3'd2,
    PH_NO_OBJ   = 3'd3,
    PH_SAMPLED  = 3'd4
  } phase_t;

  typedef enum logic [1:0] {
    CLS_RED         = 2'd0,
    CLS_BLUE        = 2'd1,
    CLS_UNKNOWN     = 2'd2,
    CLS_NOT_SAMPLED = 2'd3
  } color_t;

  // Target color codes; any other code disables rejection.
  localparam logic [TGT_W-1:0] TGT_RED  = 2'd1;
  localparam logic [TGT_W-1:0] TGT_BLUE = 2'd2;

  // Configuration register indexes.
  localparam logic [CFG_IDX_W-1:0] REG_TARGET       = 3'd0;
  localparam logic [CFG_IDX_W-1:0] REG_RED_LOW_MAX  = 3'd1;
  localparam logic [CFG_IDX_W-1:0] REG_RED_HIGH_MIN = 3'd2;
  localparam logic [CFG_IDX_W-1:0] REG_BLUE_MIN     = 3'd3;
  localparam logic [CFG_IDX_W-1:0] REG_BLUE_MAX     = 3'd4;
  localparam logic [CFG_IDX_W-1:0] REG_CONFIRM      = 3'd5;
  localparam logic [CFG_IDX_W-1:0] REG_REJECT_COOL  = 3'd6;
  localparam logic [CFG_IDX_W-1:0] REG_PASS_COOL    = 3'd7;

  // Reset values of the configuration registers.
  localparam logic [TGT_W-1:0]  RST_TARGET       = 2'd2;
  localparam logic [HUE_W-1:0]  RST_RED_LOW_MAX  = 9'd30;
  localparam logic [HUE_W-1:0]  RST_RED_HIGH_MIN = 9'd340;
  localparam logic [HUE_W-1:0]  RST_BLUE_MIN     = 9'd180;
  localparam logic [HUE_W-1:0]  RST_BLUE_MAX     = 9'd270;
  localparam logic [RUN_W-1:0]  RST_CONFIRM      = 4'd5;
  localparam logic [COOL_W-1:0] RST_REJECT_COOL  = 8'd16;
  localparam logic [COOL_W-1:0] RST_PASS_COOL    = 8'd8;

  typedef struct packed {
    logic             enabled;
    logic             object_near;
    logic [HUE_W-1:0] hue_sample;
  } in_req_t;

  typedef struct packed {
    logic             reject_pulse;
    phase_t           phase;
    logic [HUE_W-1:0] median_hue;
    color_t           color_class;
  } out_res_t;

endpackage

>>> rtl/csq_median.sv
// Rank-based median select over the valid entries of the hue window.
module csq_median (
  input  csq_pkg::hue_win_t                win,
  input  logic [csq_pkg::FILL_W-1:0]       fill,
  output logic [csq_pkg::HUE_W-1:0]        median
);

  logic [csq_pkg::FILL_W-1:0] rank [csq_pkg::HUE_WINDOW];
  logic [csq_pkg::FILL_W-1:0] half;

  assign half = fill >> 1;

  // Each valid entry gets its position in a stable ascending sort; ties are
  // broken by slot number, so the ranks of the valid entries are distinct.
  always_comb begin
    median = '0;
    for (int i = 0; i < csq_pkg::HUE_WINDOW; i++) begin
      rank[i] = '0;
      for (int j = 0; j < csq_pkg::HUE_WINDOW; j++) begin
        if ((j < fill) && ((win[j] < win[i]) || ((win[j] == win[i]) && (j < i)))) begin
          rank[i] = rank[i] + csq_pkg::FILL_W'(1);
        end
      end
      if ((i < fill) && (rank[i] == half)) begin
        median = win[i];
      end
    end
  end

endmodule

>>> rtl/color_sort_qualifier_core.sv
// Top level of the color sort qualifier: config, tick state and request pipeline.
//
//   Channel  Direction  Handshake              Payload
//   in_      request    in_valid / in_stall    csq_pkg::in_req_t  (enabled, near, hue)
//   out_     result     out_valid / out_stall  csq_pkg::out_res_t (pulse, phase, median, class)
//   cfg_     write      cfg_we                 cfg_index, cfg_data
//
// One request is taken every cycle while in_stall is low, and its result passes through
// the input register and then the result register. The whole decision for a
// tick, including the five-entry median select, is one pass of logic between those two.
// Reset (rst_n low, synchronous) restores the register defaults and clears the window,
// run counters, cooldown and wait-for-clear flag. A stall on the output holds the result
// register and, one stage back, the input register; in_stall rises only then.
module color_sort_qualifier_core (
  input  logic                             clk,
  input  logic                             rst_n,
  input  logic                             in_valid,
  output logic                             in_stall,
  input  csq_pkg::in_req_t                 in_data,
  output logic                             out_valid,
  input  logic                             out_stall,
  output csq_pkg::out_res_t                out_data,
  input  logic                             cfg_we,
  input  logic [csq_pkg::CFG_IDX_W-1:0]    cfg_index,
  input  logic [csq_pkg::CFG_DATA_W-1:0]   cfg_data
);

  // Configuration registers.
  logic [csq_pkg::TGT_W-1:0]  target_r;
  logic [csq_pkg::HUE_W-1:0]  red_low_max_r;
  logic [csq_pkg::HUE_W-1:0]  red_high_min_r;
  logic [csq_pkg::HUE_W-1:0]  blue_min_r;
  logic [csq_pkg::HUE_W-1:0]  blue_max_r;
  logic [csq_pkg::RUN_W-1:0]  confirm_r;
  logic [csq_pkg::COOL_W-1:0] reject_cool_r;
  logic [csq_pkg::COOL_W-1:0] pass_cool_r;

  // Pipeline registers.
  logic              in_valid_r;
  csq_pkg::in_req_t  in_r;
  logic              out_valid_r;
  csq_pkg::out_res_t out_r;
  csq_pkg::out_res_t out_nxt;

  // Tick state.
  csq_pkg::hue_win_t          win_r;
  csq_pkg::hue_win_t          win_nxt;
  logic [csq_pkg::POS_W-1:0]  pos_r;
  logic [csq_pkg::POS_W-1:0]  pos_nxt;
  logic [csq_pkg::FILL_W-1:0] fill_r;
  logic [csq_pkg::FILL_W-1:0] fill_nxt;
  logic [csq_pkg::RUN_W-1:0]  red_run_r;
  logic [csq_pkg::RUN_W-1:0]  red_run_nxt;
  logic [csq_pkg::RUN_W-1:0]  blue_run_r;
  logic [csq_pkg::RUN_W-1:0]  blue_run_nxt;
  logic [csq_pkg::COOL_W-1:0] cool_r;
  logic [csq_pkg::COOL_W-1:0] cool_nxt;
  logic                       await_r;
  logic                       await_nxt;

  logic                       advance;
  logic                       in_take;
  logic                       proc;
  csq_pkg::hue_win_t          win_wr;
  logic [csq_pkg::FILL_W-1:0] fill_inc;
  logic [csq_pkg::HUE_W-1:0]  median;
  csq_pkg::color_t            cls;
  logic [csq_pkg::RUN_W-1:0]  red_inc;
  logic [csq_pkg::RUN_W-1:0]  blue_inc;
  logic                       red_done;
  logic                       blue_done;
  logic                       red_pick;
  logic                       reject;

  // The result register can take a new result when it is empty or being drained.
  assign advance   = !out_valid_r || !out_stall;
  assign proc      = in_valid_r && advance;
  assign in_stall  = in_valid_r && !advance;
  assign in_take   = in_valid && !in_stall;
  assign out_valid = out_valid_r;
  assign out_data  = out_r;

  // Configuration writes.
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      target_r       <= csq_pkg::RST_TARGET;
      red_low_max_r  <= csq_pkg::RST_RED_LOW_MAX;
      red_high_min_r <= csq_pkg::RST_RED_HIGH_MIN;
      blue_min_r     <= csq_pkg::RST_BLUE_MIN;
      blue_max_r     <= csq_pkg::RST_BLUE_MAX;
      confirm_r      <= csq_pkg::RST_CONFIRM;
      reject_cool_r  <= csq_pkg::RST_REJECT_COOL;
      pass_cool_r    <= csq_pkg::RST_PASS_COOL;
    end else if (cfg_we) begin
      unique case (cfg_index)
        csq_pkg::REG_TARGET:       target_r       <= cfg_data[csq_pkg::TGT_W-1:0];
        csq_pkg::REG_RED_LOW_MAX:  red_low_max_r  <= cfg_data[csq_pkg::HUE_W-1:0];
        csq_pkg::REG_RED_HIGH_MIN: red_high_min_r <= cfg_data[csq_pkg::HUE_W-1:0];
        csq_pkg::REG_BLUE_MIN:     blue_min_r     <= cfg_data[csq_pkg::HUE_W-1:0];
        csq_pkg::REG_BLUE_MAX:     blue_max_r     <= cfg_data[csq_pkg::HUE_W-1:0];
        csq_pkg::REG_CONFIRM:      confirm_r      <= cfg_data[csq_pkg::RUN_W-1:0];
        csq_pkg::REG_REJECT_COOL:  reject_cool_r  <= cfg_data[csq_pkg::COOL_W-1:0];
        csq_pkg::REG_PASS_COOL:    pass_cool_r    <= cfg_data[csq_pkg::COOL_W-1:0];
      endcase
    end
  end

  // The sampled hue overwrites the oldest slot; the window fills from slot zero, so
  // the valid entries are always the first fill slots.
  always_comb begin
    win_wr        = win_r;
    win_wr[pos_r] = in_r.hue_sample;
    fill_inc      = (fill_r < csq_pkg::FILL_W'(csq_pkg::HUE_WINDOW))
                    ? fill_r + csq_pkg::FILL_W'(1) : fill_r;
  end

  csq_median u_median (
    .win    (win_wr),
    .fill   (fill_inc),
    .median (median)
  );

  // Red is checked first, so a hue in both bands counts as red.
  always_comb begin
    if ((median <= red_low_max_r) || (median >= red_high_min_r)) begin
      cls = csq_pkg::CLS_RED;
    end else if ((median >= blue_min_r) && (median <= blue_max_r)) begin
      cls = csq_pkg::CLS_BLUE;
    end else begin
      cls = csq_pkg::CLS_UNKNOWN;
    end
  end

  // Run counters saturate at their top value. With a confirm count of zero every
  // colored median decides, and the decision is red even for a blue median, because
  // red_pick also takes a confirmed blue as red when the confirm count is zero.
  assign red_inc   = (red_run_r != '1) ? red_run_r + csq_pkg::RUN_W'(1) : red_run_r;
  assign blue_inc  = (blue_run_r != '1) ? blue_run_r + csq_pkg::RUN_W'(1) : blue_run_r;
  assign red_done  = (cls == csq_pkg::CLS_RED) && (red_inc >= confirm_r);
  assign blue_done = (cls == csq_pkg::CLS_BLUE) && (blue_inc >= confirm_r);
  assign red_pick  = red_done || (blue_done && (confirm_r == '0));
  assign reject    = (red_pick && (target_r == csq_pkg::TGT_RED)) ||
                     (blue_done && !red_pick && (target_r == csq_pkg::TGT_BLUE));

  // One tick: the first applicable case in priority order decides the result.
  always_comb begin
    win_nxt              = win_r;
    pos_nxt              = pos_r;
    fill_nxt             = fill_r;
    red_run_nxt          = red_run_r;
    blue_run_nxt         = blue_run_r;
    cool_nxt             = cool_r;
    await_nxt            = await_r;
    out_nxt.reject_pulse = 1'b0;
    out_nxt.phase        = csq_pkg::PH_DISABLED;
    out_nxt.median_hue   = '0;
    out_nxt.color_class  = csq_pkg::CLS_NOT_SAMPLED;
    priority if (!in_r.enabled) begin
      // Disabled keeps the window but drops all decision state.
      red_run_nxt  = '0;
      blue_run_nxt = '0;
      cool_nxt     = '0;
      await_nxt    = 1'b0;
    end else if (await_r) begin
      // The tick that sees the object gone only clears the flag.
      if (!in_r.object_near) begin
        await_nxt = 1'b0;
      end
      out_nxt.phase = csq_pkg::PH_WAIT_CLR;
    end else if (cool_r != '0) begin
      cool_nxt      = cool_r - csq_pkg::COOL_W'(1);
      out_nxt.phase = csq_pkg::PH_COOLDOWN;
    end else if (!in_r.object_near) begin
      red_run_nxt   = '0;
      blue_run_nxt  = '0;
      out_nxt.phase = csq_pkg::PH_NO_OBJ;
    end else begin
      win_nxt             = win_wr;
      pos_nxt             = (pos_r == csq_pkg::POS_W'(csq_pkg::HUE_WINDOW - 1))
                            ? '0 : pos_r + csq_pkg::POS_W'(1);
      fill_nxt            = fill_inc;
      out_nxt.phase       = csq_pkg::PH_SAMPLED;
      out_nxt.median_hue  = median;
      out_nxt.color_class = cls;
      unique case (cls)
        csq_pkg::CLS_RED: begin
          red_run_nxt  = red_inc;
          blue_run_nxt = '0;
        end
        csq_pkg::CLS_BLUE: begin
          red_run_nxt  = '0;
          blue_run_nxt = blue_inc;
        end
        default: begin
          red_run_nxt  = '0;
          blue_run_nxt = '0;
        end
      endcase
      // A confirmed color restarts both runs and loads a cooldown; the target
      // color also fires the reject and waits for the object to clear.
      if (red_done || blue_done) begin
        red_run_nxt  = '0;
        blue_run_nxt = '0;
        if (reject) begin
          out_nxt.reject_pulse = 1'b1;
          cool_nxt             = reject_cool_r;
          await_nxt            = 1'b1;
        end else begin
          cool_nxt = pass_cool_r;
        end
      end
    end
  end

  // Tick state advances only when a request moves into the result register.
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      win_r      <= '0;
      pos_r      <= '0;
      fill_r     <= '0;
      red_run_r  <= '0;
      blue_run_r <= '0;
      cool_r     <= '0;
      await_r    <= 1'b0;
    end else if (proc) begin
      win_r      <= win_nxt;
      pos_r      <= pos_nxt;
      fill_r     <= fill_nxt;
      red_run_r  <= red_run_nxt;
      blue_run_r <= blue_run_nxt;
      cool_r     <= cool_nxt;
      await_r    <= await_nxt;
    end
  end

  // Input register and result register valid flags.
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      in_valid_r  <= 1'b0;
      out_valid_r <= 1'b0;
    end else begin
      if (in_take) begin
        in_valid_r <= 1'b1;
      end else if (advance) begin
        in_valid_r <= 1'b0;
      end
      if (proc) begin
        out_valid_r <= 1'b1;
      end else if (!out_stall) begin
        out_valid_r <= 1'b0;
      end
    end
  end

  // Payload registers carry no reset.
  always_ff @(posedge clk) begin
    if (in_take) begin
      in_r <= in_data;
    end
    if (proc) begin
      out_r <= out_nxt;
    end
  end

endmodule

>>> rtl/csq_checker.sv
// Port-level checker of the color sort qualifier and its bind to the top level.
`include "color_sort_qualifier_core_assert.svh"

module csq_checker (
  input logic              clk,
  input logic              rst_n,
  input logic              in_stall,
  input logic              out_valid,
  input logic              out_stall,
  input csq_pkg::out_res_t out_data
);

  logic res_held;
  logic res_reject;
  logic res_sampled;
  logic res_colored;
  logic res_blank;

  assign res_held    = out_valid && out_stall;
  assign res_reject  = out_valid && out_data.reject_pulse;
  assign res_sampled = (out_data.phase == csq_pkg::PH_SAMPLED);
  assign res_colored = (out_data.color_class == csq_pkg::CLS_RED) ||
                       (out_data.color_class == csq_pkg::CLS_BLUE);
  assign res_blank   = (out_data.median_hue == '0) &&
                       (out_data.color_class == csq_pkg::CLS_NOT_SAMPLED);

  // A stalled result keeps its value until it is taken.
  `CSQ_ASSERT(a_out_hold, res_held |=> out_valid && $stable(out_data), "held result changed")

  // The input side only stalls behind a full, stalled result register.
  `CSQ_ASSERT_ALWAYS(a_stall_cause, in_stall |-> res_held, "input stalled without a held result")

  // A reject only comes from a sampled tick that confirmed red or blue.
  `CSQ_ASSERT(a_reject_src, res_reject |-> res_sampled && res_colored, "reject without a color")

  // Ticks that do not sample carry no median and no color.
  `CSQ_ASSERT(a_idle_fields, out_valid && !res_sampled |-> res_blank, "stray median or color")

endmodule

bind color_sort_qualifier_core csq_checker u_csq_checker (.*);
